>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros vanish in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GAPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define GAPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GAPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GAPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/gaps_pkg.sv
package gaps_pkg;

    localparam int OUT_ROWS = 32;
    localparam int ROW_BITS = 32;

    typedef logic [1:0] pq_op_t;

    localparam pq_op_t PQ_NOP   = 2'd0;
    localparam pq_op_t PQ_PUSH  = 2'd1;
    localparam pq_op_t PQ_POP   = 2'd2;
    localparam pq_op_t PQ_FLUSH = 2'd3;

    typedef struct packed {
        logic empty;
        logic full;
    } pq_status_t;

endpackage

>>> rtl/grid_astar_path_search_top.sv
// Channel   Dir  tdata fields (low bit up)                         tlast      tuser
// s_        in   row_index[4:0] open_bits[36:5]                     last_row   -
// m_        out  out_row[4:0] path_bits[36:5] seen_bits[68:37]      final_row  found, heap_overflow
// cfg_      in   write enable, register index, data                 -          -
// Rows load one word per cycle while s_tready is high. The row with tlast starts a search:
// a clearing pass over all 2^(2*clog2(MAX_DIM)) cost cells (1024 by default), a start step,
// popped entries, expansion of cells over their in-grid open neighbors, and the path trace.
// Results then leave one per cycle while m_tready is high.
// No input word is taken from the search start until the last result has been loaded.
// Reset is synchronous, active low, and empties the open set.
module grid_astar_path_search_top #(
    parameter int MAX_DIM    = 32,
    parameter int HEAP_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index[4:0], open_bits[36:5]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_row[4:0], path_bits[36:5], seen_bits[68:37]
    output logic [1:0]  m_tuser,   // found[0], heap_overflow[1]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_wdata
);
    import gaps_pkg::*;

    localparam int IDXW  = $clog2(MAX_DIM);
    localparam int DIMW  = IDXW + 1;
    localparam int CELLW = 2 * IDXW;
    localparam int GW    = CELLW + 1;
    localparam int FW    = GW + 6;
    localparam int EW    = FW + GW + CELLW;
    localparam int MW    = GW + 3;
    localparam int NCELL = 1 << CELLW;
    localparam logic [GW-1:0] G_INF = '1;

    localparam logic [2:0] CFG_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SROW   = 3'd2;
    localparam logic [2:0] CFG_SCOL   = 3'd3;
    localparam logic [2:0] CFG_GROW   = 3'd4;
    localparam logic [2:0] CFG_GCOL   = 3'd5;
    localparam logic [2:0] CFG_GAIN   = 3'd6;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [2:0] PD_NONE  = 3'd0;
    localparam logic [2:0] PD_UP    = 3'd1;
    localparam logic [2:0] PD_RIGHT = 3'd2;
    localparam logic [2:0] PD_DOWN  = 3'd3;
    localparam logic [2:0] PD_LEFT  = 3'd4;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_INIT     = 4'd2;
    localparam logic [3:0] ST_POP      = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_NBR      = 4'd5;
    localparam logic [3:0] ST_NBR_CMP  = 4'd6;
    localparam logic [3:0] ST_TRACE_RD = 4'd7;
    localparam logic [3:0] ST_TRACE_ST = 4'd8;
    localparam logic [3:0] ST_EMIT     = 4'd9;

    function automatic logic [11:0] heur_f(input logic [7:0] r, input logic [7:0] c,
                                           input logic [7:0] gr, input logic [7:0] gc,
                                           input logic [3:0] k);
        logic [7:0] dr, dc, s;
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        s  = dr + dc;
        return {4'd0, s} * {8'd0, k};
    endfunction

    // Configuration registers
    logic [5:0] height_reg, width_reg;
    logic [4:0] srow_reg, scol_reg, grow_reg, gcol_reg;
    logic [3:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 6'd32;
            width_reg  <= 6'd32;
            srow_reg   <= 5'd0;
            scol_reg   <= 5'd0;
            grow_reg   <= 5'd31;
            gcol_reg   <= 5'd31;
            gain_reg   <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEIGHT: height_reg <= cfg_wdata;
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_SROW:   srow_reg   <= cfg_wdata[4:0];
                CFG_SCOL:   scol_reg   <= cfg_wdata[4:0];
                CFG_GROW:   grow_reg   <= cfg_wdata[4:0];
                CFG_GCOL:   gcol_reg   <= cfg_wdata[4:0];
                CFG_GAIN:   gain_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // State
    logic [3:0]       state_reg, state_next;
    logic [DIMW-1:0]  h_reg, h_next, w_reg, w_next, h_eff, w_eff;
    logic [5:0]       emit_reg, emit_next;
    logic [CELLW-1:0] clr_reg, clr_next;
    logic [EW-1:0]    cur_reg, cur_next;
    logic [1:0]       dir_reg, dir_next;
    logic [CELLW-1:0] nb_cell_reg, nb_cell_next;
    logic [11:0]      hv_reg, hv_next;
    logic [IDXW-1:0]  tr_r_reg, tr_r_next, tr_c_reg, tr_c_next;
    logic             found_reg, found_next, ovf_reg, ovf_next;
    logic [4:0]       row_cnt_reg, row_cnt_next;
    logic [MW-1:0]    rd_reg;
    logic [MW-1:0]    cost_mem [NCELL];
    logic [ROW_BITS-1:0] wall_reg [OUT_ROWS];
    logic [ROW_BITS-1:0] seen_reg [OUT_ROWS];
    logic [ROW_BITS-1:0] path_reg [OUT_ROWS];

    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;

    // Control and datapath
    logic             in_acc, rows_clr, seen_set, path_set, out_load;
    logic             mem_we;
    logic [CELLW-1:0] mem_wa, mem_ra;
    logic [MW-1:0]    mem_wd;
    pq_op_t           pq_op;
    logic [EW-1:0]    pq_new, pq_top;
    pq_status_t       pq_status;

    logic [GW-1:0]    cur_g, rd_g, tg;
    logic [CELLW-1:0] cur_cell, s_cell, nb_cell;
    logic [IDXW-1:0]  cur_r, cur_c;
    logic [2:0]       rd_pd;
    logic [7:0]       r8, c8, nr8, nc8, hr_in, hc_in;
    logic             nb_ok, nb_go, outside, at_goal;
    logic [11:0]      hv;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_acc && ({27'd0, s_tdata[4:0]} < 32'(MAX_DIM))) begin
            wall_reg[s_tdata[4:0]] <= s_tdata[36:5];
        end
    end

    always_comb begin
        if (height_reg == 6'd0) begin
            h_eff = DIMW'(1);
        end else if (7'(height_reg) > 7'(MAX_DIM)) begin
            h_eff = DIMW'(MAX_DIM);
        end else begin
            h_eff = DIMW'(height_reg);
        end
        if (width_reg == 6'd0) begin
            w_eff = DIMW'(1);
        end else if (7'(width_reg) > 7'(MAX_DIM)) begin
            w_eff = DIMW'(MAX_DIM);
        end else begin
            w_eff = DIMW'(width_reg);
        end
    end

    assign cur_g    = cur_reg[CELLW +: GW];
    assign cur_cell = cur_reg[CELLW-1:0];
    assign cur_r    = cur_cell[CELLW-1 -: IDXW];
    assign cur_c    = cur_cell[IDXW-1:0];
    assign rd_g     = rd_reg[MW-1 -: GW];
    assign rd_pd    = rd_reg[2:0];
    assign tg       = cur_g + GW'(1);
    assign s_cell   = {IDXW'(srow_reg), IDXW'(scol_reg)};
    assign r8       = 8'(cur_r);
    assign c8       = 8'(cur_c);

    assign outside = (8'(srow_reg) >= 8'(h_reg)) || (8'(scol_reg) >= 8'(w_reg)) ||
                     (8'(grow_reg) >= 8'(h_reg)) || (8'(gcol_reg) >= 8'(w_reg));
    assign at_goal = (r8 == 8'(grow_reg)) && (c8 == 8'(gcol_reg));

    always_comb begin
        nr8   = r8;
        nc8   = c8;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_UP: begin
                nr8   = r8 - 8'd1;
                nb_ok = (r8 != 8'd0);
            end
            DIR_RIGHT: begin
                nc8   = c8 + 8'd1;
                nb_ok = (nc8 < 8'(w_reg));
            end
            DIR_DOWN: begin
                nr8   = r8 + 8'd1;
                nb_ok = (nr8 < 8'(h_reg));
            end
            DIR_LEFT: begin
                nc8   = c8 - 8'd1;
                nb_ok = (c8 != 8'd0);
            end
            default: ;
        endcase
    end

    // Rows past the loadable range and columns past the row word are walls.
    assign nb_go   = nb_ok && (nr8 < 8'(OUT_ROWS)) && (nc8 < 8'(ROW_BITS)) &&
                     wall_reg[nr8[4:0]][nc8[4:0]];
    assign nb_cell = {nr8[IDXW-1:0], nc8[IDXW-1:0]};

    assign hr_in = (state_reg == ST_INIT) ? 8'(srow_reg) : nr8;
    assign hc_in = (state_reg == ST_INIT) ? 8'(scol_reg) : nc8;
    assign hv    = heur_f(hr_in, hc_in, 8'(grow_reg), 8'(gcol_reg), gain_reg);

    always_comb begin
        state_next   = state_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        emit_next    = emit_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        dir_next     = dir_reg;
        nb_cell_next = nb_cell_reg;
        hv_next      = hv_reg;
        tr_r_next    = tr_r_reg;
        tr_c_next    = tr_c_reg;
        found_next   = found_reg;
        ovf_next     = ovf_reg;
        row_cnt_next = row_cnt_reg;
        rows_clr     = 1'b0;
        seen_set     = 1'b0;
        path_set     = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = nb_cell_reg;
        mem_wd       = {tg, PD_NONE};
        mem_ra       = nb_cell;
        pq_op        = PQ_NOP;
        pq_new       = {FW'(tg) + FW'(hv_reg), tg, nb_cell_reg};
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = ST_CLEAR;
                    clr_next   = '0;
                    h_next     = h_eff;
                    w_next     = w_eff;
                    emit_next  = (7'(h_eff) > 7'(OUT_ROWS)) ? 6'(OUT_ROWS) : 6'(h_eff);
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    rows_clr   = 1'b1;
                    pq_op      = PQ_FLUSH;
                end
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = {G_INF, PD_NONE};
                if (clr_reg == CELLW'(NCELL - 1)) begin
                    state_next = ST_INIT;
                end else begin
                    clr_next = clr_reg + CELLW'(1);
                end
            end
            ST_INIT: begin
                row_cnt_next = '0;
                if (outside) begin
                    state_next = ST_EMIT;
                end else begin
                    mem_we     = 1'b1;
                    mem_wa     = s_cell;
                    mem_wd     = {GW'(0), PD_NONE};
                    pq_op      = PQ_PUSH;
                    pq_new     = {FW'(hv), GW'(0), s_cell};
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (pq_status.empty) begin
                    state_next = ST_EMIT;
                end else begin
                    cur_next   = pq_top;
                    pq_op      = PQ_POP;
                    mem_ra     = pq_top[CELLW-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (at_goal) begin
                    tr_r_next  = cur_r;
                    tr_c_next  = cur_c;
                    state_next = ST_TRACE_RD;
                end else if (cur_g > rd_g) begin
                    state_next = ST_POP;
                end else begin
                    seen_set   = 1'b1;
                    dir_next   = DIR_UP;
                    state_next = ST_NBR;
                end
            end
            ST_NBR: begin
                if (nb_go) begin
                    nb_cell_next = nb_cell;
                    hv_next      = hv;
                    state_next   = ST_NBR_CMP;
                end else if (dir_reg == DIR_LEFT) begin
                    state_next = ST_POP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            ST_NBR_CMP: begin
                if (tg < rd_g) begin
                    mem_we = 1'b1;
                    mem_wd = {tg, {1'b0, dir_reg} + 3'd1};
                    // A push into a full open set is dropped, the cell keeps its new cost.
                    if (pq_status.full) begin
                        ovf_next = 1'b1;
                    end else begin
                        pq_op = PQ_PUSH;
                    end
                end
                if (dir_reg == DIR_LEFT) begin
                    state_next = ST_POP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NBR;
                end
            end
            ST_TRACE_RD: begin
                mem_ra     = {tr_r_reg, tr_c_reg};
                state_next = ST_TRACE_ST;
            end
            ST_TRACE_ST: begin
                path_set = 1'b1;
                if (rd_pd == PD_NONE) begin
                    found_next = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    case (rd_pd)
                        PD_UP:    tr_r_next = tr_r_reg + IDXW'(1);
                        PD_RIGHT: tr_c_next = tr_c_reg - IDXW'(1);
                        PD_DOWN:  tr_r_next = tr_r_reg - IDXW'(1);
                        PD_LEFT:  tr_c_next = tr_c_reg + IDXW'(1);
                        default: ;
                    endcase
                    state_next = ST_TRACE_RD;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (6'(row_cnt_reg) + 6'd1 == emit_reg) begin
                        state_next = ST_LOAD;
                    end else begin
                        row_cnt_next = row_cnt_reg + 5'd1;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg       <= h_next;
        w_reg       <= w_next;
        emit_reg    <= emit_next;
        clr_reg     <= clr_next;
        cur_reg     <= cur_next;
        dir_reg     <= dir_next;
        nb_cell_reg <= nb_cell_next;
        hv_reg      <= hv_next;
        tr_r_reg    <= tr_r_next;
        tr_c_reg    <= tr_c_next;
        row_cnt_reg <= row_cnt_next;
    end

    // Cost memory: cost and parent direction of each cell, one write and one read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cost_mem[mem_wa] <= mem_wd;
        end
        rd_reg <= cost_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (rows_clr) begin
            for (int i = 0; i < OUT_ROWS; i++) begin
                seen_reg[i] <= '0;
                path_reg[i] <= '0;
            end
        end else begin
            if (seen_set) begin
                seen_reg[5'(cur_r)][5'(cur_c)] <= 1'b1;
            end
            if (path_set) begin
                path_reg[5'(tr_r_reg)][5'(tr_c_reg)] <= 1'b1;
            end
        end
    end

    gaps_pq_chain #(.DEPTH(HEAP_DEPTH), .EW(EW), .FW(FW)) u_open (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_i     (pq_op),
        .new_i    (pq_new),
        .top_o    (pq_top),
        .status_o (pq_status)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {3'd0, seen_reg[row_cnt_reg],
                            found_reg ? path_reg[row_cnt_reg] : 32'd0, row_cnt_reg};
            m_tuser_reg <= {ovf_reg, found_reg};
            m_tlast_reg <= (6'(row_cnt_reg) + 6'd1 == emit_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/gaps_pq_cell.sv
module gaps_pq_cell #(
    parameter int EW = 40,
    parameter int FW = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gaps_pkg::pq_op_t     op_i,
    input  logic [EW-1:0]        new_i,
    input  logic [EW-1:0]        left_entry_i,
    input  logic                 left_valid_i,
    input  logic                 left_take_i,
    input  logic [EW-1:0]        right_entry_i,
    input  logic                 right_valid_i,
    output logic [EW-1:0]        entry_o,
    output logic                 valid_o,
    output logic                 take_o
);
    import gaps_pkg::*;

    logic [EW-1:0] entry_reg, entry_next;
    logic          valid_reg, valid_next;

    // The key sits in the top bits. A new word goes behind every entry of equal key,
    // so the oldest of equal keys stays in front.
    assign take_o = !valid_reg || (new_i[EW-1 -: FW] < entry_reg[EW-1 -: FW]);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (op_i)
            PQ_PUSH: begin
                if (take_o && left_take_i) begin
                    entry_next = left_entry_i;
                    valid_next = left_valid_i;
                end else if (take_o) begin
                    entry_next = new_i;
                    valid_next = 1'b1;
                end
            end
            PQ_POP: begin
                entry_next = right_entry_i;
                valid_next = right_valid_i;
            end
            PQ_FLUSH: valid_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;
    assign valid_o = valid_reg;

endmodule

>>> rtl/gaps_pq_chain.sv
`include "assert_macros.svh"

module gaps_pq_chain #(
    parameter int DEPTH = 4096,
    parameter int EW    = 40,
    parameter int FW    = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gaps_pkg::pq_op_t      op_i,
    input  logic [EW-1:0]         new_i,
    output logic [EW-1:0]         top_o,
    output gaps_pkg::pq_status_t  status_o
);
    import gaps_pkg::*;

    logic [EW-1:0] ent [DEPTH];
    logic          vld [DEPTH];
    logic          tk  [DEPTH];

    genvar gi;
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [EW-1:0] left_e, right_e;
        logic          left_v, left_t, right_v;
        if (gi == 0) begin : g_head
            assign left_e = '0;
            assign left_v = 1'b0;
            assign left_t = 1'b0;
        end else begin : g_mid
            assign left_e = ent[gi-1];
            assign left_v = vld[gi-1];
            assign left_t = tk[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_tail
            assign right_e = '0;
            assign right_v = 1'b0;
        end else begin : g_body
            assign right_e = ent[gi+1];
            assign right_v = vld[gi+1];
        end
        gaps_pq_cell #(.EW(EW), .FW(FW)) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .op_i          (op_i),
            .new_i         (new_i),
            .left_entry_i  (left_e),
            .left_valid_i  (left_v),
            .left_take_i   (left_t),
            .right_entry_i (right_e),
            .right_valid_i (right_v),
            .entry_o       (ent[gi]),
            .valid_o       (vld[gi]),
            .take_o        (tk[gi])
        );
    end

    assign top_o          = ent[0];
    assign status_o.empty = !vld[0];
    assign status_o.full  = vld[DEPTH-1];

    `GAPS_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, op_i == PQ_POP, vld[0])
    `GAPS_ASSERT_IMP(a_push_room, aclk, aresetn, op_i == PQ_PUSH, !vld[DEPTH-1])
    `GAPS_ASSERT_NXT(a_flush_empties, aclk, aresetn, op_i == PQ_FLUSH, !vld[0])
    `GAPS_ASSERT_IMP(a_head_order, aclk, aresetn, vld[1], ent[0][EW-1 -: FW] <= ent[1][EW-1 -: FW])

endmodule
